FILE: rtl/core/brf_pkg.sv
package brf_pkg;

    // fixed widths of the item fields
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 11;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_DROP  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // request payload
    typedef struct packed {
        t_cmd              command;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  drop_count;
    } t_req;

    // response payload
    typedef struct packed {
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic [CNT_W-1:0]  moved_count;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  free_space;
    } t_rsp;

endpackage

FILE: rtl/core/brf_if.sv
// request channel
interface brf_req_if;
    logic          valid;
    logic          ready;
    brf_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// response channel
interface brf_rsp_if;
    logic          valid;
    logic          ready;
    brf_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/brf_store.sv
module brf_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [brf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [brf_pkg::BYTE_W-1:0] o_rdata
);

    logic [brf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [brf_pkg::BYTE_W-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/byte_ring_fifo_with_discard.sv
// Byte ring FIFO of DEPTH bytes (a power of two) with put, get, discard and
// clear commands. Every request returns one response carrying the fill level
// and free space after the command. A new request is taken every clock cycle
// unless responses stall; each response passes through the store read stage
// and then the output register. The write and read counters are updated as
// the request is taken, so back-to-back requests see each other's effect. Two
// response slots (store read stage and output register) decouple the request
// side from a stalled response side. The byte store is not cleared at reset
// and needs no clearing pass; a get only reads bytes already put.
module byte_ring_fifo_with_discard #(
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brf_req_if.sink       i_req,
    brf_rsp_if.source     o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int MW = (CW > brf_pkg::CNT_W) ? CW : brf_pkg::CNT_W;

    logic [CW-1:0] r_wr_cnt, n_wr_cnt;
    logic [CW-1:0] r_rd_cnt, n_rd_cnt;

    logic [CW-1:0] fill_now;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] free_next;
    logic [CW-1:0] drop_n;
    logic [CW-1:0] moved;
    logic [MW-1:0] req_ext;
    logic [MW-1:0] fill_ext;
    logic [MW-1:0] moved_ext;
    logic [MW-1:0] fill_next_ext;
    logic [MW-1:0] free_next_ext;
    logic          wr_en;
    logic          rd_en;
    logic          done;
    logic          is_get;

    logic                       accept;
    logic                       s1_go;
    logic                       r_s1_valid;
    logic                       r_s1_get;
    brf_pkg::t_rsp              r_s1_rsp;
    logic                       r_out_valid;
    brf_pkg::t_rsp              r_out_rsp;
    logic [brf_pkg::BYTE_W-1:0] rdata;

    // handshake, no transfer while in reset
    assign s1_go       = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_s1_valid || s1_go);
    assign accept      = i_req.valid && i_req.ready;

    // discard count clamped to the fill level
    assign fill_now = r_wr_cnt - r_rd_cnt;
    assign req_ext  = MW'(i_req.data.drop_count);
    assign fill_ext = MW'(fill_now);
    assign drop_n   = (req_ext < fill_ext) ? req_ext[CW-1:0] : fill_now;

    // command decode and next counters
    always_comb begin
        n_wr_cnt = r_wr_cnt;
        n_rd_cnt = r_rd_cnt;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        done     = 1'b0;
        is_get   = 1'b0;
        moved    = '0;
        case (i_req.data.command)
            brf_pkg::CMD_PUT: begin
                if (!fill_now[CW-1]) begin
                    wr_en    = 1'b1;
                    n_wr_cnt = r_wr_cnt + 1'b1;
                    done     = 1'b1;
                    moved    = CW'(1);
                end
            end
            brf_pkg::CMD_GET: begin
                is_get = 1'b1;
                if (fill_now != '0) begin
                    rd_en    = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                    done     = 1'b1;
                    moved    = CW'(1);
                end
                if (n_rd_cnt == r_wr_cnt) begin
                    n_wr_cnt = '0;
                    n_rd_cnt = '0;
                end
            end
            brf_pkg::CMD_DROP: begin
                n_rd_cnt = r_rd_cnt + drop_n;
                moved    = drop_n;
                if (n_rd_cnt == r_wr_cnt) begin
                    n_wr_cnt = '0;
                    n_rd_cnt = '0;
                end
            end
            brf_pkg::CMD_CLEAR: begin
                n_wr_cnt = '0;
                n_rd_cnt = '0;
            end
            default: begin
                n_wr_cnt = '0;
                n_rd_cnt = '0;
            end
        endcase
    end

    // levels after the command
    assign fill_next     = n_wr_cnt - n_rd_cnt;
    assign free_next     = CW'(DEPTH) - fill_next;
    assign moved_ext     = MW'(moved);
    assign fill_next_ext = MW'(fill_next);
    assign free_next_ext = MW'(free_next);

    // byte store
    brf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && wr_en),
        .i_waddr (r_wr_cnt[AW-1:0]),
        .i_wdata (i_req.data.data_byte),
        .i_re    (accept && rd_en),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rdata)
    );

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt <= '0;
            r_rd_cnt <= '0;
        end else if (accept) begin
            r_wr_cnt <= n_wr_cnt;
            r_rd_cnt <= n_rd_cnt;
        end
    end

    // store read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_get             <= is_get && done;
            r_s1_rsp.done_res    <= done;
            r_s1_rsp.read_byte   <= '0;
            r_s1_rsp.moved_count <= moved_ext[brf_pkg::CNT_W-1:0];
            r_s1_rsp.fill_level  <= fill_next_ext[brf_pkg::CNT_W-1:0];
            r_s1_rsp.free_space  <= free_next_ext[brf_pkg::CNT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_rsp.done_res    <= r_s1_rsp.done_res;
            r_out_rsp.read_byte   <= r_s1_get ? rdata : r_s1_rsp.read_byte;
            r_out_rsp.moved_count <= r_s1_rsp.moved_count;
            r_out_rsp.fill_level  <= r_s1_rsp.fill_level;
            r_out_rsp.free_space  <= r_s1_rsp.free_space;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_rsp;

endmodule

FILE: tb/tb_byte_ring_fifo_with_discard.sv
module tb_byte_ring_fifo_with_discard;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH  = 1024;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int RUN_LIMIT  = 1000000;
    localparam int BACKLOG_AT = 160;
    localparam int BACKLOG_LEN = 400;
    localparam int RAND_ITEMS = 377;

    // mirror of the ring contents and the responses it still owes
    class ring_fifo_scoreboard;
        logic [brf_pkg::BYTE_W-1:0] byte_mirror [BUF_DEPTH];
        logic [brf_pkg::CNT_W-1:0]  wr_ptr;
        logic [brf_pkg::CNT_W-1:0]  rd_ptr;
        brf_pkg::t_rsp              owed_rsp [$];
        int unsigned                mismatch_cnt;

        function new();
            wr_ptr       = '0;
            rd_ptr       = '0;
            mismatch_cnt = 0;
        endfunction

        // apply one accepted request and queue its expected status
        function void note_request(input brf_pkg::t_req r);
            brf_pkg::t_rsp             e;
            logic [brf_pkg::CNT_W-1:0] fill;
            logic [brf_pkg::CNT_W-1:0] n;
            e    = '0;
            fill = wr_ptr - rd_ptr;
            case (r.command)
                brf_pkg::CMD_PUT: begin
                    if (fill < BUF_DEPTH) begin
                        byte_mirror[wr_ptr[ADDR_W-1:0]] = r.data_byte;
                        wr_ptr        = wr_ptr + 1'b1;
                        e.done_res    = 1'b1;
                        e.moved_count = brf_pkg::CNT_W'(1);
                    end
                end
                brf_pkg::CMD_GET: begin
                    if (fill != 0) begin
                        e.read_byte   = byte_mirror[rd_ptr[ADDR_W-1:0]];
                        rd_ptr        = rd_ptr + 1'b1;
                        e.done_res    = 1'b1;
                        e.moved_count = brf_pkg::CNT_W'(1);
                    end
                end
                brf_pkg::CMD_DROP: begin
                    n             = (r.drop_count < fill) ? r.drop_count : fill;
                    rd_ptr        = rd_ptr + n;
                    e.moved_count = n;
                end
                default: begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                end
            endcase
            // pointers snap back to zero once the ring runs dry
            if (r.command != brf_pkg::CMD_PUT && rd_ptr == wr_ptr) begin
                rd_ptr = '0;
                wr_ptr = '0;
            end
            fill         = wr_ptr - rd_ptr;
            e.fill_level = fill;
            e.free_space = brf_pkg::CNT_W'(BUF_DEPTH) - fill;
            owed_rsp.push_back(e);
        endfunction

        function void report(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
            $display("%0t ns: %s expected %0d got %0d", $time, field, exp_v, act_v);
            mismatch_cnt++;
        endfunction

        // compare one response transfer with the oldest owed status
        function void check_response(input brf_pkg::t_rsp got);
            brf_pkg::t_rsp e;
            if (owed_rsp.size() == 0) begin
                $display("%0t ns: response with none owed, expected nothing got %h",
                         $time, got);
                mismatch_cnt++;
                return;
            end
            e = owed_rsp.pop_front();
            if (got.done_res !== e.done_res)
                report("done_res", e.done_res, got.done_res);
            if (got.read_byte !== e.read_byte)
                report("read_byte", e.read_byte, got.read_byte);
            if (got.moved_count !== e.moved_count)
                report("moved_count", e.moved_count, got.moved_count);
            if (got.fill_level !== e.fill_level)
                report("fill_level", e.fill_level, got.fill_level);
            if (got.free_space !== e.free_space)
                report("free_space", e.free_space, got.free_space);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   calm_left;

    brf_req_if req_ch ();
    brf_rsp_if rsp_ch ();

    ring_fifo_scoreboard sb = new();

    byte_ring_fifo_with_discard #(
        .DEPTH (BUF_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watch both channels for transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.data);
        end
    end

    // random gap after a request, with calm stretches of back-to-back traffic
    task automatic pause_sender();
        int gap;
        int pick;
        gap = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                calm_left = $urandom_range(20, 80);
            else if (pick < 8)
                gap = $urandom_range(10, 30);
            else if (pick >= 50)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // offer one request and hold it until transferred
    task automatic send_req(input brf_pkg::t_cmd c,
                            input logic [brf_pkg::BYTE_W-1:0] d,
                            input logic [brf_pkg::CNT_W-1:0] n);
        brf_pkg::t_req r;
        r.command    = c;
        r.data_byte  = d;
        r.drop_count = n;
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pause_sender();
    endtask

    // random byte and random discard field
    function automatic logic [brf_pkg::BYTE_W-1:0] pick_byte();
        return brf_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [brf_pkg::CNT_W-1:0] pick_count();
        return brf_pkg::CNT_W'($urandom_range(0, 1024));
    endfunction

    // discard count, mostly small with an occasional large request
    function automatic logic [brf_pkg::CNT_W-1:0] pick_drop();
        if ($urandom_range(0, 9) < 7)
            return brf_pkg::CNT_W'($urandom_range(0, 6));
        return brf_pkg::CNT_W'($urandom_range(0, 1024));
    endfunction

    // response side: random stalls, stall-free stretches, one long backlog
    initial begin
        int rsp_cycle;
        int hold_left;
        int stall_left;
        int seg_left;
        bit no_stall;
        rsp_cycle  = 0;
        hold_left  = 0;
        stall_left = 0;
        seg_left   = 0;
        no_stall   = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_cycle++;
            if (rsp_cycle == BACKLOG_AT)
                hold_left = BACKLOG_LEN;
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 200);
                no_stall = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!no_stall && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // request side and end of run
    initial begin
        int pick;
        calm_left    = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, field extremes, every command
        send_req(brf_pkg::CMD_GET,   8'h00, 11'd0);
        send_req(brf_pkg::CMD_DROP,  8'hFF, 11'd0);
        send_req(brf_pkg::CMD_DROP,  8'h00, 11'd1024);
        send_req(brf_pkg::CMD_PUT,   8'h00, 11'd1024);
        send_req(brf_pkg::CMD_PUT,   8'hFF, 11'd1023);
        send_req(brf_pkg::CMD_PUT,   8'hA5, 11'd0);
        send_req(brf_pkg::CMD_PUT,   8'h5A, 11'd0);
        send_req(brf_pkg::CMD_DROP,  8'h00, 11'd0);
        send_req(brf_pkg::CMD_GET,   8'hFF, 11'd1024);
        send_req(brf_pkg::CMD_GET,   8'h00, 11'd1023);
        send_req(brf_pkg::CMD_DROP,  8'h00, 11'd1);
        // discard beyond the fill level, ring runs dry
        send_req(brf_pkg::CMD_DROP,  8'h00, 11'd1023);
        send_req(brf_pkg::CMD_GET,   8'h00, 11'd0);
        send_req(brf_pkg::CMD_PUT,   8'h3C, 11'd5);
        send_req(brf_pkg::CMD_PUT,   8'hC3, 11'd0);
        send_req(brf_pkg::CMD_CLEAR, 8'hFF, 11'd1024);
        send_req(brf_pkg::CMD_GET,   8'h00, 11'd0);
        send_req(brf_pkg::CMD_PUT,   8'h81, 11'd0);
        send_req(brf_pkg::CMD_GET,   8'h00, 11'd0);
        send_req(brf_pkg::CMD_PUT,   8'h7E, 11'd0);
        send_req(brf_pkg::CMD_PUT,   8'h11, 11'd0);
        send_req(brf_pkg::CMD_GET,   8'h00, 11'd0);
        send_req(brf_pkg::CMD_DROP,  8'h00, 11'd1);

        // random mix of commands
        repeat (RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_req(brf_pkg::CMD_PUT, pick_byte(), pick_count());
            else if (pick < 80)
                send_req(brf_pkg::CMD_GET, pick_byte(), pick_count());
            else if (pick < 94)
                send_req(brf_pkg::CMD_DROP, pick_byte(), pick_drop());
            else
                send_req(brf_pkg::CMD_CLEAR, pick_byte(), pick_count());
        end
        req_ch.valid <= 1'b0;

        // drain owed responses, then watch for strays
        @(posedge i_clk);
        while (sb.owed_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
